@@ hdl/arra_pkg.sv @@
// Package for the audio ring rate adapter: sizes, register indexes, reset values
// and the structs that pass between the sequencer and the shared divider.
// No dependencies.
package arra_pkg;

  localparam int RING_DEPTH       = 1024;
  localparam int ENDPOINT_BUFFERS = 3;
  localparam int NOMINAL_SAMPLES  = 16;

  localparam int PTR_W    = $clog2(RING_DEPTH);
  localparam int SAMPLE_W = 16;
  localparam int WORD_W   = 2 * SAMPLE_W;
  localparam int TIMER_W  = 32;
  localparam int LIM_W    = 9;
  localparam int EP_W     = 2;
  localparam int BYTES_W  = 7;
  localparam int N_W      = $clog2(NOMINAL_SAMPLES + 2);
  localparam int CNT_W    = $clog2(TIMER_W + 1);
  localparam int DEV_W    = ((PTR_W > LIM_W) ? PTR_W : LIM_W) + 2;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_RING_PERIOD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESYNC_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIM_LIMIT   = 2'd2;

  localparam logic [TIMER_W-1:0] RING_PERIOD_RESET  = 32'd6144000;
  localparam logic [LIM_W-1:0]   RESYNC_LIMIT_RESET = 9'd50;
  localparam logic [LIM_W-1:0]   TRIM_LIMIT_RESET   = 9'd5;

  // Command to the shared divider. In fraction mode the remainder is loaded
  // with init and zeros are shifted in; otherwise init is the dividend.
  typedef struct packed {
    logic               start;
    logic               frac_mode;
    logic [TIMER_W-1:0] init;
  } arra_div_cmd_t;

  typedef struct packed {
    logic               done;
    logic [TIMER_W-1:0] rem;
    logic [PTR_W-1:0]   quo;
  } arra_div_sts_t;

endpackage

@@ hdl/arra_ring_mem.sv @@
// Sample ring storage: one write port and one read port with registered data.
// Depends on arra_pkg for depth and word width.
module arra_ring_mem (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [arra_pkg::PTR_W-1:0] waddr_i,
  input  logic [arra_pkg::WORD_W-1:0] wdata_i,
  input  logic                       re_i,
  input  logic [arra_pkg::PTR_W-1:0] raddr_i,
  output logic [arra_pkg::WORD_W-1:0] rdata_o
);

  logic [arra_pkg::WORD_W-1:0] mem_q [arra_pkg::RING_DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ hdl/arra_divider.sv @@
// Shared restoring divider, one quotient bit per cycle. Computes a 32-bit
// remainder modulo the period, or the fraction bits of rem * RING_DEPTH / period.
// Depends on arra_pkg for widths and the command and status structs.
module arra_divider (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [arra_pkg::TIMER_W-1:0] period_i,
  input  arra_pkg::arra_div_cmd_t      cmd_i,
  output arra_pkg::arra_div_sts_t      sts_o
);

  logic                         busy_q, busy_d;
  logic                         done_q, done_d;
  logic [arra_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic [arra_pkg::CNT_W-1:0]   last_q, last_d;
  logic [arra_pkg::TIMER_W-1:0] rem_q, rem_d;
  logic [arra_pkg::TIMER_W-1:0] sh_q, sh_d;
  logic [arra_pkg::PTR_W-1:0]   quo_q, quo_d;

  logic [arra_pkg::TIMER_W:0]   cand;
  logic [arra_pkg::TIMER_W:0]   diff;
  logic                         ge;

  assign cand = {rem_q, sh_q[arra_pkg::TIMER_W-1]};
  assign diff = cand - {1'b0, period_i};
  assign ge   = (cand >= {1'b0, period_i});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    last_d = last_q;
    rem_d  = rem_q;
    sh_d   = sh_q;
    quo_d  = quo_q;
    if (cmd_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = '0;
      if (cmd_i.frac_mode) begin
        rem_d  = cmd_i.init;
        sh_d   = '0;
        last_d = arra_pkg::CNT_W'(arra_pkg::PTR_W - 1);
      end else begin
        rem_d  = '0;
        sh_d   = cmd_i.init;
        last_d = arra_pkg::CNT_W'(arra_pkg::TIMER_W - 1);
      end
    end else if (busy_q) begin
      rem_d = ge ? diff[arra_pkg::TIMER_W-1:0] : cand[arra_pkg::TIMER_W-1:0];
      sh_d  = {sh_q[arra_pkg::TIMER_W-2:0], 1'b0};
      quo_d = {quo_q[arra_pkg::PTR_W-2:0], ge};
      cnt_d = cnt_q + arra_pkg::CNT_W'(1);
      if (cnt_q == last_q) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      last_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      last_q <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    sh_q  <= sh_d;
    quo_q <= quo_d;
  end

  assign sts_o.done = done_q;
  assign sts_o.rem  = rem_q;
  assign sts_o.quo  = quo_q;

endmodule

@@ hdl/audio_ring_rate_adapter.sv @@
// Top level of the audio ring rate adapter: handshakes, configuration,
// request sequencer and pointer state. Uses arra_pkg, arra_divider, arra_ring_mem.
//
// A write transfer (tuser 0) stores one stereo pair and leaves the block in idle;
// the block is ready again in the next cycle. A packet request (tuser 1) runs
// the shared one-bit-per-cycle divider three times: the timer modulo the ring
// period, the wrap timestamp modulo the period and the ten position bits. The
// combine state then folds the residues and the decide state makes the decision.
// Each of the 15 to 17 sample pairs then passes through the read, load and send
// states for the ring read and the output transfer, and after the last pair the
// block returns to idle. When the period register is zero the divider passes are
// skipped. Ring entries never written read as zero; this follows from the write
// pointer fill mark, so there is no clearing pass after reset. The block is not
// ready during a request.
module audio_ring_rate_adapter (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration write port.
  input  logic                             cfg_we_i,
  input  logic [arra_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [arra_pkg::TIMER_W-1:0]     cfg_wdata_i,
  // Input stream.
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // tdata: left_sample [15:0], right_sample [31:16], timer_now [63:32].
  input  logic [63:0]                      s_axis_tdata_i,
  // tuser: action [0].
  input  logic                             s_axis_tuser_i,
  // Output stream.
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // tdata: left_out [15:0], right_out [31:16], packet_bytes [38:32], zero [39].
  output logic [39:0]                      m_axis_tdata_o,
  // tuser: endpoint_buffer [1:0], resynced [2].
  output logic [2:0]                       m_axis_tuser_o,
  output logic                             m_axis_tlast_o
);

  localparam int PTR_W   = arra_pkg::PTR_W;
  localparam int TIMER_W = arra_pkg::TIMER_W;
  localparam int N_W     = arra_pkg::N_W;
  localparam int DEV_W   = arra_pkg::DEV_W;
  localparam logic [PTR_W-1:0] HALF = PTR_W'(arra_pkg::RING_DEPTH / 2);
  localparam logic [PTR_W-1:0] LAST_ENTRY = PTR_W'(arra_pkg::RING_DEPTH - 1);

  typedef enum logic [8:0] {
    ST_IDLE    = 9'b000000001,
    ST_MOD_NOW = 9'b000000010,
    ST_MOD_TS  = 9'b000000100,
    ST_COMBINE = 9'b000001000,
    ST_FRAC    = 9'b000010000,
    ST_DECIDE  = 9'b000100000,
    ST_READ    = 9'b001000000,
    ST_LOAD    = 9'b010000000,
    ST_SEND    = 9'b100000000
  } arra_state_e;

  arra_state_e state_q, state_d;

  logic [TIMER_W-1:0]         period_q;
  logic [arra_pkg::LIM_W-1:0] resync_lim_q, trim_lim_q;

  logic [PTR_W-1:0]           wp_q, rp_q, rp_d;
  logic                       wrapped_q;
  logic [TIMER_W-1:0]         wrap_ts_q;
  logic [arra_pkg::EP_W-1:0]  bsel_q, ep_q;
  logic [TIMER_W-1:0]         tn_q, ts_q;
  logic [PTR_W-1:0]           pos_q;
  logic [N_W-1:0]             n_q, k_q;
  logic                       resync_q;
  logic                       rd_valid_q;

  logic                       tvalid_q;
  logic [arra_pkg::WORD_W-1:0] out_word_q;
  logic                       out_last_q;

  arra_pkg::arra_div_cmd_t    div_cmd;
  arra_pkg::arra_div_sts_t    div_sts;
  logic [arra_pkg::WORD_W-1:0] rdata;

  logic                       in_xfer, out_xfer;
  logic                       mem_we, mem_re;
  logic [TIMER_W-1:0]         t_val;
  logic [PTR_W-1:0]           expected, dev_raw;
  logic signed [DEV_W-1:0]    dev, rlim, tlim;
  logic                       do_resync;
  logic [N_W-1:0]             n_new;

  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_xfer = tvalid_q && m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign mem_we = in_xfer && !s_axis_tuser_i;
  assign mem_re = (state_q == ST_READ);

  // Both residues are below the period, so one conditional add folds the gap.
  assign t_val = (tn_q >= ts_q) ? (tn_q - ts_q)
               : TIMER_W'(({1'b0, tn_q} + {1'b0, period_q}) - {1'b0, ts_q});

  assign expected = pos_q + HALF;
  assign dev_raw  = rp_q - expected + HALF;
  assign dev      = $signed({{(DEV_W-PTR_W){1'b0}}, dev_raw}) - $signed(DEV_W'(HALF));
  assign rlim     = $signed(DEV_W'(resync_lim_q));
  assign tlim     = $signed(DEV_W'(trim_lim_q));
  assign do_resync = (dev > rlim) || (dev < -rlim);

  always_comb begin
    n_new = N_W'(arra_pkg::NOMINAL_SAMPLES);
    if (do_resync) begin
      n_new = N_W'(arra_pkg::NOMINAL_SAMPLES);
    end else if (dev < -tlim) begin
      n_new = N_W'(arra_pkg::NOMINAL_SAMPLES + 1);
    end else if (dev > tlim) begin
      n_new = N_W'(arra_pkg::NOMINAL_SAMPLES - 1);
    end
  end

  always_comb begin
    state_d = state_q;
    div_cmd.start     = 1'b0;
    div_cmd.frac_mode = 1'b0;
    div_cmd.init      = s_axis_tdata_i[63:32];
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer && s_axis_tuser_i) begin
          if (period_q == '0) begin
            state_d = ST_DECIDE;
          end else begin
            div_cmd.start = 1'b1;
            state_d = ST_MOD_NOW;
          end
        end
      end
      ST_MOD_NOW: begin
        if (div_sts.done) begin
          div_cmd.start = 1'b1;
          div_cmd.init  = wrap_ts_q;
          state_d = ST_MOD_TS;
        end
      end
      ST_MOD_TS: begin
        if (div_sts.done) begin
          state_d = ST_COMBINE;
        end
      end
      ST_COMBINE: begin
        div_cmd.start     = 1'b1;
        div_cmd.frac_mode = 1'b1;
        div_cmd.init      = t_val;
        state_d = ST_FRAC;
      end
      ST_FRAC: begin
        if (div_sts.done) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: state_d = ST_READ;
      ST_READ:   state_d = ST_LOAD;
      ST_LOAD:   state_d = ST_SEND;
      ST_SEND: begin
        if (out_xfer) begin
          state_d = out_last_q ? ST_IDLE : ST_READ;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    rp_d = rp_q;
    if (state_q == ST_DECIDE && do_resync) begin
      rp_d = expected;
    end else if (state_q == ST_SEND && out_xfer) begin
      rp_d = rp_q + PTR_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      period_q     <= arra_pkg::RING_PERIOD_RESET;
      resync_lim_q <= arra_pkg::RESYNC_LIMIT_RESET;
      trim_lim_q   <= arra_pkg::TRIM_LIMIT_RESET;
      wp_q         <= '0;
      rp_q         <= '0;
      wrapped_q    <= 1'b0;
      wrap_ts_q    <= '0;
      bsel_q       <= '0;
      tvalid_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      rp_q    <= rp_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          arra_pkg::CFG_RING_PERIOD:  period_q     <= cfg_wdata_i;
          arra_pkg::CFG_RESYNC_LIMIT: resync_lim_q <= cfg_wdata_i[arra_pkg::LIM_W-1:0];
          arra_pkg::CFG_TRIM_LIMIT:   trim_lim_q   <= cfg_wdata_i[arra_pkg::LIM_W-1:0];
          default: ;
        endcase
      end
      if (mem_we) begin
        wp_q <= wp_q + PTR_W'(1);
        if (wp_q == LAST_ENTRY) begin
          wrapped_q <= 1'b1;
          wrap_ts_q <= s_axis_tdata_i[63:32];
        end
      end
      if (state_q == ST_DECIDE) begin
        if (bsel_q == arra_pkg::EP_W'(arra_pkg::ENDPOINT_BUFFERS - 1)) begin
          bsel_q <= '0;
        end else begin
          bsel_q <= bsel_q + arra_pkg::EP_W'(1);
        end
      end
      if (state_q == ST_LOAD) begin
        tvalid_q <= 1'b1;
      end else if (out_xfer) begin
        tvalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      pos_q <= '0;
    end
    if (state_q == ST_MOD_NOW && div_sts.done) begin
      tn_q <= div_sts.rem;
    end
    if (state_q == ST_MOD_TS && div_sts.done) begin
      ts_q <= div_sts.rem;
    end
    if (state_q == ST_FRAC && div_sts.done) begin
      pos_q <= div_sts.quo;
    end
    if (state_q == ST_DECIDE) begin
      n_q      <= n_new;
      k_q      <= '0;
      resync_q <= do_resync;
      ep_q     <= bsel_q;
    end
    if (state_q == ST_READ) begin
      // Entries past the fill mark before the first wrap were never written.
      rd_valid_q <= wrapped_q || (rp_q < wp_q);
    end
    if (state_q == ST_LOAD) begin
      out_word_q <= rd_valid_q ? rdata : '0;
      out_last_q <= (k_q == n_q - N_W'(1));
    end
    if (state_q == ST_SEND && out_xfer) begin
      k_q <= k_q + N_W'(1);
    end
  end

  arra_divider u_divider (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .period_i (period_q),
    .cmd_i    (div_cmd),
    .sts_o    (div_sts)
  );

  arra_ring_mem u_ring (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (wp_q),
    .wdata_i (s_axis_tdata_i[31:0]),
    .re_i    (mem_re),
    .raddr_i (rp_q),
    .rdata_o (rdata)
  );

  assign m_axis_tvalid_o = tvalid_q;
  assign m_axis_tdata_o  = {1'b0, arra_pkg::BYTES_W'({n_q, 2'b00}), out_word_q};
  assign m_axis_tuser_o  = {resync_q, ep_q};
  assign m_axis_tlast_o  = out_last_q;

  a_valid_only_in_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (state_q == ST_SEND))
    else $error("output valid outside the send state");

  a_no_accept_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !m_axis_tvalid_o)
    else $error("input ready while a result is pending");

  a_last_ends_packet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_xfer && m_axis_tlast_o) |=> (state_q == ST_IDLE))
    else $error("sequencer did not return to idle after the final pair");

  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_sts.done |-> (state_q == ST_MOD_NOW || state_q == ST_MOD_TS
                      || state_q == ST_FRAC))
    else $error("divider finished outside a wait state");

endmodule
